// ----- rtl/tpd_pkg.sv -----
// ============================================================================
// tpd_pkg
// Shared constants and the result layout of the touch packet deframer.
// ============================================================================
package tpd_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned STORE_AW   = 3;
    localparam int unsigned STORE_D    = 8;
    localparam int unsigned COORD_W    = 16;
    localparam int unsigned FLAGS_W    = 3;
    localparam int unsigned RESULT_W   = 69;
    localparam int unsigned OUT_DATA_W = 72;

    localparam logic [BYTE_W-1:0]  SYNC_BYTE    = 8'h55;
    localparam logic [BYTE_W-1:0]  SUM_SEED     = 8'hAA;
    localparam logic [BYTE_W-1:0]  TOUCH_TYPE   = 8'h54;
    localparam logic [FLAGS_W-1:0] FLAG_PRESS   = 3'h1;
    localparam logic [FLAGS_W-1:0] FLAG_STREAM  = 3'h2;
    localparam logic [FLAGS_W-1:0] FLAG_RELEASE = 3'h4;
    localparam logic [POS_W-1:0]   POS_SYNC     = 4'd0;
    localparam logic [POS_W-1:0]   POS_LAST     = 4'd9;

    typedef struct packed {
        logic [COORD_W-1:0] z_pressure;
        logic [COORD_W-1:0] y_position;
        logic [COORD_W-1:0] x_position;
        logic [FLAGS_W-1:0] touch_flags;
        logic [BYTE_W-1:0]  raw_byte_two;
        logic               is_touch;
        logic [BYTE_W-1:0]  packet_type;
        logic               checksum_good;
    } result_t;

endpackage

// ----- rtl/touch_packet_deframer.sv -----
// ============================================================================
// touch_packet_deframer
// Reassembles 10-byte sync-led touch controller packets and reports each
// complete packet with its checksum status and decoded fields.
// ============================================================================
//
//  channel   direction  beat content
//  s_axis    in         one received serial byte
//  m_axis    out        one decoded packet per checksum byte
//
//  One byte per cycle sustained. A byte is registered, then decoded by the
//  position, add and compare logic into the result register.
//  Reset returns to waiting for sync with the checksum seed loaded.
//  A stalled result blocks only a checksum byte; other bytes keep flowing.
module touch_packet_deframer
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [tpd_pkg::BYTE_W-1:0]         s_axis_tdata,  // [7:0] rx_byte
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] checksum_good, [8:1] packet_type, [9] is_touch, [17:10] raw_byte_two,
    // [20:18] touch_flags, [36:21] x_position, [52:37] y_position,
    // [68:53] z_pressure, [71:69] zero
    output logic [tpd_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    logic                           in_valid_reg;
    logic [tpd_pkg::BYTE_W-1:0]     in_data_reg;
    logic [tpd_pkg::POS_W-1:0]      pos_reg;
    logic [tpd_pkg::POS_W-1:0]      pos_next;
    logic [tpd_pkg::BYTE_W-1:0]     sum_reg;
    logic [tpd_pkg::BYTE_W-1:0]     sum_next;
    logic [tpd_pkg::BYTE_W-1:0]     store_reg [tpd_pkg::STORE_D];
    logic                           out_valid_reg;
    tpd_pkg::result_t               out_data_reg;
    tpd_pkg::result_t               result;

    logic                           at_sync;
    logic                           at_last;
    logic                           out_free;
    logic                           advance;
    logic                           store_we;
    logic [tpd_pkg::STORE_AW-1:0]   store_addr;
    logic [tpd_pkg::POS_W-1:0]      pos_minus_one;

    assign at_sync  = (pos_reg == tpd_pkg::POS_SYNC);
    assign at_last  = (pos_reg >= tpd_pkg::POS_LAST);
    assign out_free = !out_valid_reg || m_axis_tready;
    assign advance  = in_valid_reg && (!at_last || out_free);

    assign s_axis_tready = !in_valid_reg || advance;

    assign pos_minus_one = pos_reg - tpd_pkg::POS_W'(1);
    assign store_addr    = pos_minus_one[tpd_pkg::STORE_AW-1:0];
    assign store_we      = advance && !at_sync && !at_last;

    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        if (at_sync)
        begin
            if (in_data_reg == tpd_pkg::SYNC_BYTE)
            begin
                pos_next = tpd_pkg::POS_W'(1);
                sum_next = sum_reg + in_data_reg;
            end
        end
        else if (!at_last)
        begin
            pos_next = pos_reg + tpd_pkg::POS_W'(1);
            sum_next = sum_reg + in_data_reg;
        end
        else
        begin
            pos_next = tpd_pkg::POS_SYNC;
            sum_next = tpd_pkg::SUM_SEED;
        end
    end

    always_comb
    begin
        result.checksum_good = (sum_reg == in_data_reg);
        result.packet_type   = store_reg[0];
        result.is_touch      = (store_reg[0] == tpd_pkg::TOUCH_TYPE);
        result.raw_byte_two  = store_reg[1];
        result.touch_flags   = store_reg[1][tpd_pkg::FLAGS_W-1:0]
                               & (tpd_pkg::FLAG_PRESS | tpd_pkg::FLAG_STREAM
                                  | tpd_pkg::FLAG_RELEASE);
        result.x_position    = {store_reg[3], store_reg[2]};
        result.y_position    = {store_reg[5], store_reg[4]};
        result.z_pressure    = {store_reg[7], store_reg[6]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            pos_reg       <= tpd_pkg::POS_SYNC;
            sum_reg       <= tpd_pkg::SUM_SEED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                pos_reg <= pos_next;
                sum_reg <= sum_next;
            end
            if (advance && at_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata;
        end
        if (store_we)
        begin
            store_reg[store_addr] <= in_data_reg;
        end
        if (advance && at_last)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(tpd_pkg::OUT_DATA_W - tpd_pkg::RESULT_W)'(0), out_data_reg};

endmodule
